>>> sv/pim_pkg.sv
// Package for the pulse-per-second interval monitor.
// Holds the command, status and register codes, reset values and the word types.
// Has no dependencies.
package pim_pkg;

    localparam logic [1:0] CMD_PULSE     = 2'd0;
    localparam logic [1:0] CMD_SET_SECS  = 2'd1;
    localparam logic [1:0] CMD_CLR_OFS   = 2'd2;

    localparam logic [2:0] ST_DISABLED   = 3'd0;
    localparam logic [2:0] ST_FIRST      = 3'd1;
    localparam logic [2:0] ST_WARMUP     = 3'd2;
    localparam logic [2:0] ST_SHORT      = 3'd3;
    localparam logic [2:0] ST_LONG       = 3'd4;
    localparam logic [2:0] ST_ACCEPTED   = 3'd5;
    localparam logic [2:0] ST_CMD_DONE   = 3'd6;

    localparam logic [1:0] CFG_SHORT_THR = 2'd0;
    localparam logic [1:0] CFG_LONG_THR  = 2'd1;
    localparam logic [1:0] CFG_HAS_REF   = 2'd2;
    localparam logic [1:0] CFG_DISABLED  = 2'd3;

    localparam logic [31:0] SHORT_THR_RESET = 32'd999500;
    localparam logic [31:0] LONG_THR_RESET  = 32'd1000500;

    localparam logic signed [31:0] OFFSET_HALF = 32'sd500000;
    localparam logic signed [31:0] OFFSET_FULL = 32'sd1000000;
    localparam logic [31:0]        WARMUP_SECS = 32'd3;

    typedef struct packed {
        logic [31:0] short_thr;
        logic [31:0] long_thr;
        logic        has_ref;
        logic        disabled;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        stamp_us;
        logic signed [31:0] wrapped_ofs;
        logic [31:0]        new_seconds;
    } t_work;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        seconds;
        logic signed [31:0] offset_us;
        logic [31:0]        interval_us;
        logic [31:0]        min_interval_us;
        logic [31:0]        max_interval_us;
        logic [31:0]        short_count;
        logic [31:0]        long_count;
    } t_result;

endpackage

>>> sv/pim_fifo.sv
// Small first-in first-out queue of register entries with show-ahead read.
// Generic in depth and word type; no package dependency.
module pim_fifo #(
    parameter int DEPTH = 2,
    parameter type t_data = logic [7:0]
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_data o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/pim_front.sv
// Front end: accepts input words and precomputes the wrapped reference offset.
// Depends on pim_pkg for the work word type and offset constants.
module pim_front (
    input  logic            i_push,
    input  logic            i_full,
    input  logic [1:0]      i_command,
    input  logic [31:0]     i_stamp_us,
    input  logic [31:0]     i_ref_stamp_us,
    input  logic [31:0]     i_new_seconds,
    output logic            o_wr,
    output pim_pkg::t_work  o_work
);
    import pim_pkg::*;

    logic signed [31:0] diff;
    logic signed [31:0] diff_lo;
    logic signed [31:0] diff_hi;

    // The offset depends only on the two timestamps, so it is settled here.
    assign diff    = signed'(i_stamp_us - i_ref_stamp_us);
    assign diff_lo = diff - OFFSET_FULL;
    assign diff_hi = diff + OFFSET_FULL;

    always_comb begin
        o_work.command     = i_command;
        o_work.stamp_us    = i_stamp_us;
        o_work.new_seconds = i_new_seconds;
        if (diff > OFFSET_HALF) begin
            o_work.wrapped_ofs = diff_lo;
        end else if (diff < -OFFSET_HALF) begin
            o_work.wrapped_ofs = diff_hi;
        end else begin
            o_work.wrapped_ofs = diff;
        end
    end

    assign o_wr = i_push && !i_full;

endmodule

>>> sv/pim_back.sv
// Back end: holds the monitor state and turns each work word into a result word.
// Depends on pim_pkg for codes, constants and the word types.
module pim_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pim_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  pim_pkg::t_work    i_work,
    output logic              o_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output pim_pkg::t_result  o_result
);
    import pim_pkg::*;

    logic [31:0]        r_last_stamp, n_last_stamp;
    logic [31:0]        r_seconds, n_seconds;
    logic signed [31:0] r_offset, n_offset;
    logic [31:0]        r_min, n_min;
    logic [31:0]        r_max, n_max;
    logic [31:0]        r_short_cnt, n_short_cnt;
    logic [31:0]        r_long_cnt, n_long_cnt;
    logic [2:0]         status;
    logic [31:0]        interval;
    logic [31:0]        secs_inc;
    logic               fire;

    assign fire       = i_valid && !i_res_full;
    assign o_pop      = fire;
    assign o_res_push = fire;
    assign secs_inc   = r_seconds + 32'd1;

    always_comb begin
        n_last_stamp = r_last_stamp;
        n_seconds    = r_seconds;
        n_offset     = r_offset;
        n_min        = r_min;
        n_max        = r_max;
        n_short_cnt  = r_short_cnt;
        n_long_cnt   = r_long_cnt;
        status       = ST_CMD_DONE;
        interval     = '0;
        case (i_work.command)
            CMD_PULSE: begin
                n_last_stamp = i_work.stamp_us;
                if (i_cfg.disabled) begin
                    status = ST_DISABLED;
                end else if (r_last_stamp == '0) begin
                    // A stored stamp of zero means no pulse has been seen yet.
                    status = ST_FIRST;
                end else begin
                    n_seconds = secs_inc;
                    if (i_cfg.has_ref) begin
                        n_offset = i_work.wrapped_ofs;
                    end
                    if (secs_inc < WARMUP_SECS) begin
                        status = ST_WARMUP;
                    end else begin
                        interval = i_work.stamp_us - r_last_stamp;
                        if (interval < i_cfg.short_thr) begin
                            n_short_cnt = r_short_cnt + 32'd1;
                            n_min       = '0;
                            status      = ST_SHORT;
                        end else begin
                            if (r_min == '0 || interval < r_min) begin
                                n_min = interval;
                            end
                            if (interval > i_cfg.long_thr) begin
                                n_long_cnt = r_long_cnt + 32'd1;
                                n_max      = '0;
                                status     = ST_LONG;
                            end else begin
                                if (r_max == '0 || interval > r_max) begin
                                    n_max = interval;
                                end
                                status = ST_ACCEPTED;
                            end
                        end
                    end
                end
            end
            CMD_SET_SECS: begin
                n_seconds = i_work.new_seconds;
            end
            CMD_CLR_OFS: begin
                n_offset = '0;
            end
            default: begin
                status = ST_CMD_DONE;
            end
        endcase
    end

    always_comb begin
        o_result.status          = status;
        o_result.seconds         = n_seconds;
        o_result.offset_us       = n_offset;
        o_result.interval_us     = interval;
        o_result.min_interval_us = n_min;
        o_result.max_interval_us = n_max;
        o_result.short_count     = n_short_cnt;
        o_result.long_count      = n_long_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp <= '0;
            r_seconds    <= '0;
            r_offset     <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_short_cnt  <= '0;
            r_long_cnt   <= '0;
        end else if (fire) begin
            r_last_stamp <= n_last_stamp;
            r_seconds    <= n_seconds;
            r_offset     <= n_offset;
            r_min        <= n_min;
            r_max        <= n_max;
            r_short_cnt  <= n_short_cnt;
            r_long_cnt   <= n_long_cnt;
        end
    end

endmodule

>>> sv/pps_pulse_interval_monitor.sv
// Pulse-per-second interval monitor, top level with configuration registers.
// A pushed word is held in the middle queue, turned into a result by the
// combinational back end and written into the output queue, where it can be
// popped. Throughput: one word per cycle while the output queue is not full.
// Reset (synchronous, active low) empties both queues, clears all state and
// restores the register defaults; no clearing pass is needed.
module pps_pulse_interval_monitor #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_stamp_us,
    input  logic [31:0]        i_ref_stamp_us,
    input  logic [31:0]        i_new_seconds,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [2:0]         o_status,
    output logic [31:0]        o_seconds,
    output logic signed [31:0] o_offset_us,
    output logic [31:0]        o_interval_us,
    output logic [31:0]        o_min_interval_us,
    output logic [31:0]        o_max_interval_us,
    output logic [31:0]        o_short_count,
    output logic [31:0]        o_long_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import pim_pkg::*;

    t_cfg    r_cfg;
    t_work   front_work;
    t_work   mid_work;
    t_result back_result;
    t_result out_result;
    logic    front_wr;
    logic    mid_empty;
    logic    back_pop;
    logic    res_push;
    logic    res_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_thr <= SHORT_THR_RESET;
            r_cfg.long_thr  <= LONG_THR_RESET;
            r_cfg.has_ref   <= 1'b0;
            r_cfg.disabled  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SHORT_THR: r_cfg.short_thr <= i_cfg_data;
                CFG_LONG_THR:  r_cfg.long_thr  <= i_cfg_data;
                CFG_HAS_REF:   r_cfg.has_ref   <= i_cfg_data[0];
                CFG_DISABLED:  r_cfg.disabled  <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    pim_front u_front (
        .i_push         (i_push),
        .i_full         (o_full),
        .i_command      (i_command),
        .i_stamp_us     (i_stamp_us),
        .i_ref_stamp_us (i_ref_stamp_us),
        .i_new_seconds  (i_new_seconds),
        .o_wr           (front_wr),
        .o_work         (front_work)
    );

    pim_fifo #(
        .DEPTH  (MID_DEPTH),
        .t_data (t_work)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_wr),
        .i_data  (front_work),
        .o_full  (o_full),
        .i_pop   (back_pop),
        .o_empty (mid_empty),
        .o_data  (mid_work)
    );

    pim_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (!mid_empty),
        .i_work     (mid_work),
        .o_pop      (back_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_result   (back_result)
    );

    pim_fifo #(
        .DEPTH  (OUT_DEPTH),
        .t_data (t_result)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (out_result)
    );

    assign o_status          = out_result.status;
    assign o_seconds         = out_result.seconds;
    assign o_offset_us       = out_result.offset_us;
    assign o_interval_us     = out_result.interval_us;
    assign o_min_interval_us = out_result.min_interval_us;
    assign o_max_interval_us = out_result.max_interval_us;
    assign o_short_count     = out_result.short_count;
    assign o_long_count      = out_result.long_count;

endmodule
